/* hdl/b64_pkg.sv */
// shared types, constants and symbol mapping for the base64 stream decoder
package b64_pkg;

  // default depth of the job queue between front and back
  localparam int unsigned B64_QDEPTH = 4;

  // alphabet offsets
  localparam logic [7:0] LOWER_BASE = 8'd26;
  localparam logic [7:0] DIGIT_BASE = 8'd52;
  localparam logic [5:0] PLUS_CODE  = 6'd62;
  localparam logic [5:0] SLASH_CODE = 6'd63;

  // character classes
  typedef enum logic [1:0] {
    SYM_DATA,
    SYM_PAD,
    SYM_BAD
  } sym_kind_t;

  typedef struct packed {
    sym_kind_t   kind;
    logic [5:0]  val;
  } sym_t;

  // one queued job: up to three bytes or one error result
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nb;
    logic        err;
    logic        eom;
  } b64_job_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // map one ASCII character to its sextet or class
  function automatic sym_t map_symbol(input logic [7:0] c);
    sym_t s;
    s.kind = SYM_BAD;
    s.val  = '0;
    if (c >= "A" && c <= "Z") begin
      s.kind = SYM_DATA;
      s.val  = 6'(c - "A");
    end else if (c >= "a" && c <= "z") begin
      s.kind = SYM_DATA;
      s.val  = 6'(c - "a" + LOWER_BASE);
    end else if (c >= "0" && c <= "9") begin
      s.kind = SYM_DATA;
      s.val  = 6'(c - "0" + DIGIT_BASE);
    end else if (c == "+") begin
      s.kind = SYM_DATA;
      s.val  = PLUS_CODE;
    end else if (c == "/") begin
      s.kind = SYM_DATA;
      s.val  = SLASH_CODE;
    end else if (c == "=") begin
      s.kind = SYM_PAD;
    end
    return s;
  endfunction

endpackage

/* hdl/b64_in_if.sv */
// character input channel: valid/ready with symbol and end mark
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_message;

  modport source (output valid, output symbol, output end_of_message, input ready);
  modport sink   (input valid, input symbol, input end_of_message, output ready);
endinterface

/* hdl/b64_out_if.sv */
// decoded result channel: valid/ready with byte, flags and last mark
interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       error;
  logic       last;

  modport source (output valid, output data_byte, output byte_valid, output error,
                  output last, input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input error,
                  input last, output ready);
endinterface

/* hdl/b64_front.sv */
// front end: accepts characters, tracks group state, builds output jobs
module b64_front
  import b64_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  b64_in_if.sink    in_ch,
  input  q_stat_t   q_stat,
  output logic      push,
  output b64_job_t  job
);

  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        sticky_r, sticky_nxt;

  sym_t        sym;
  logic        accept;
  logic        eom;
  logic        err;
  logic [1:0]  nb;
  logic [23:0] word;
  logic [17:0] acc_sh;
  logic [1:0]  pos_inc;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign eom         = in_ch.end_of_message;
  assign sym         = map_symbol(in_ch.symbol);
  assign acc_sh      = {acc_r[11:0], sym.val};
  assign pos_inc     = pos_r + 2'd1;

  // classify the character and work out the next group state
  always_comb begin
    acc_nxt    = acc_r;
    pos_nxt    = pos_r;
    pad_nxt    = pad_r;
    sticky_nxt = sticky_r;
    err        = 1'b0;
    nb         = 2'd0;
    word       = '0;
    if (sticky_r) begin
      // discard until end mark
      if (eom) begin
        acc_nxt    = '0;
        pos_nxt    = '0;
        pad_nxt    = '0;
        sticky_nxt = 1'b0;
      end
    end else begin
      if (sym.kind == SYM_BAD) begin
        err = 1'b1;
      end else if (pad_r != 2'd0 && pos_r == 2'd0) begin
        err = 1'b1;
      end else if (sym.kind == SYM_PAD) begin
        if (pos_r < 2'd2) begin
          err = 1'b1;
        end else if (pos_r == 2'd2) begin
          pad_nxt = 2'd1;
          acc_nxt = {acc_r[11:0], 6'd0};
          pos_nxt = 2'd3;
          if (eom) err = 1'b1;
        end else begin
          word    = {acc_r, 6'd0};
          nb      = pad_r[0] ? 2'd1 : 2'd2;
          pad_nxt = {1'b0, pad_r[0]} + 2'd1;
          pos_nxt = 2'd0;
          acc_nxt = '0;
        end
      end else if (pad_r != 2'd0) begin
        err = 1'b1;
      end else if (pos_r == 2'd3) begin
        word    = {acc_r, sym.val};
        nb      = 2'd3;
        pos_nxt = 2'd0;
        acc_nxt = '0;
      end else begin
        acc_nxt = acc_sh;
        pos_nxt = pos_inc;
        if (eom) begin
          if (pos_inc == 2'd1) begin
            err = 1'b1;
          end else if (pos_inc == 2'd2) begin
            word = {acc_sh[11:0], 12'd0};
            nb   = 2'd1;
          end else begin
            word = {acc_sh, 6'd0};
            nb   = 2'd2;
          end
        end
      end
      // end mark clears everything, otherwise an error turns sticky
      if (eom) begin
        acc_nxt    = '0;
        pos_nxt    = '0;
        pad_nxt    = '0;
        sticky_nxt = 1'b0;
      end else if (err) begin
        sticky_nxt = 1'b1;
      end
    end
  end

  // job handed to the queue
  assign job.word = err ? 24'd0 : word;
  assign job.nb   = err ? 2'd1 : nb;
  assign job.err  = err;
  assign job.eom  = eom;
  assign push     = accept && !sticky_r && (err || nb != 2'd0);

  // group state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      pos_r    <= '0;
      pad_r    <= '0;
      sticky_r <= 1'b0;
    end else if (accept) begin
      acc_r    <= acc_nxt;
      pos_r    <= pos_nxt;
      pad_r    <= pad_nxt;
      sticky_r <= sticky_nxt;
    end
  end

endmodule

/* hdl/b64_queue.sv */
// small job queue between front and back
module b64_queue
  import b64_pkg::*;
#(
  parameter int unsigned DEPTH = B64_QDEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  b64_job_t push_job,
  input  logic     pop,
  output b64_job_t head_job,
  output q_stat_t  q_stat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  b64_job_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_job     = mem[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + CW'(1);
    if (!do_push && do_pop) count_nxt = count_r - CW'(1);
  end

  // job storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_job;
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
  end

endmodule

/* hdl/b64_back.sv */
// back end: splits queued jobs into results and drives the output register
module b64_back
  import b64_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  b64_job_t  head_job,
  input  q_stat_t   q_stat,
  output logic      pop,
  b64_out_if.source out_ch
);

  logic [1:0] idx_r;
  logic       out_valid_r;
  logic [7:0] data_r;
  logic       byte_valid_r;
  logic       error_r;
  logic       last_r;

  logic       load;
  logic       final_res;
  logic [7:0] sel_byte;

  assign load      = !q_stat.empty && (!out_valid_r || out_ch.ready);
  assign final_res = head_job.err || (idx_r == head_job.nb - 2'd1);
  assign pop       = load && final_res;

  // byte select, most significant first
  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = head_job.word[23:16];
      2'd1:    sel_byte = head_job.word[15:8];
      default: sel_byte = head_job.word[7:0];
    endcase
  end

  // result index and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= final_res ? 2'd0 : idx_r + 2'd1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_r       <= head_job.err ? 8'd0 : sel_byte;
      byte_valid_r <= !head_job.err;
      error_r      <= head_job.err;
      last_r       <= head_job.eom && final_res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.data_byte  = data_r;
  assign out_ch.byte_valid = byte_valid_r;
  assign out_ch.error      = error_r;
  assign out_ch.last       = last_r;

endmodule

/* hdl/base64_stream_decoder_core.sv */
// flow: an accepted character's job is queued, then loaded into the output register
// throughput: one character per cycle while the job queue has room
// output: one result per cycle unless stalled; four data characters give three results
// stall: the queue (QDEPTH jobs) lets input continue while the output is held
// reset: synchronous active-low rst_n clears group state, queue and output valid
module base64_stream_decoder_core
  import b64_pkg::*;
#(
  parameter int unsigned QDEPTH = B64_QDEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  b64_in_if.sink    in_ch,
  b64_out_if.source out_ch
);

  logic     push;
  logic     pop;
  b64_job_t push_job;
  b64_job_t head_job;
  q_stat_t  q_stat;

  // character classification and group tracking
  b64_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (push),
    .job    (push_job)
  );

  // decoupling queue
  b64_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  // result sequencing
  b64_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

/* hdl/b64_checker.sv */
// port-level checks on the decoder result channel, bound to the top level
module b64_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data_byte,
  input logic       out_byte_valid,
  input logic       out_error,
  input logic       out_last
);

  // a stalled result stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data_byte) && $stable(out_byte_valid)
                                && $stable(out_error) && $stable(out_last))
    else $error("result payload changed while stalled");

  // each result is either a byte or an error
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_valid != out_error))
    else $error("result is neither byte nor error, or both");

  // an error result carries a zero byte
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_data_byte == 8'd0)
    else $error("error result with nonzero data");

endmodule

bind base64_stream_decoder_core b64_checker u_b64_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_data_byte  (out_ch.data_byte),
  .out_byte_valid (out_ch.byte_valid),
  .out_error      (out_ch.error),
  .out_last       (out_ch.last)
);

/* bench/base64_stream_decoder_core_tb.sv */
// self-checking bench for the base64 stream decoder core: scoreboard class plus driver tasks
module base64_stream_decoder_core_tb
  import b64_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // one decoded result as seen on the output channel
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       error;
    logic       last;
  } dec_result_t;

  // tracks decoder state, predicts results per character and checks them in order
  class b64_decode_tracker;
    logic [17:0]  acc;
    logic [1:0]   grp;
    logic [1:0]   pads;
    logic         sticky;
    dec_result_t  pending_results[$];
    int           fail_count;
    int           checked_count;
    int           error_results;

    function new();
      clear_group();
      fail_count    = 0;
      checked_count = 0;
      error_results = 0;
    endfunction

    function void clear_group();
      acc    = '0;
      grp    = '0;
      pads   = '0;
      sticky = 1'b0;
    endfunction

    // character class and sextet value of one ASCII code
    function void classify(input logic [7:0] c, output sym_kind_t kind, output logic [5:0] val);
      kind = SYM_DATA;
      val  = '0;
      if (c >= "A" && c <= "Z") val = 6'(c - "A");
      else if (c >= "a" && c <= "z") val = 6'(c - "a") + 6'd26;
      else if (c >= "0" && c <= "9") val = 6'(c - "0") + 6'd52;
      else if (c == "+") val = 6'd62;
      else if (c == "/") val = 6'd63;
      else if (c == "=") kind = SYM_PAD;
      else kind = SYM_BAD;
    endfunction

    // note one accepted character; returns 0 when it was swallowed after an error
    function bit note_symbol(input logic [7:0] sym, input logic eom);
      sym_kind_t   kind;
      logic [5:0]  val;
      logic        err;
      logic [23:0] word;
      int          nb;
      dec_result_t r;
      err  = 1'b0;
      word = '0;
      nb   = 0;
      classify(sym, kind, val);

      // suppressed until the end mark
      if (sticky) begin
        if (eom) clear_group();
        return 1'b0;
      end

      if (kind == SYM_BAD) begin
        err = 1'b1;
      end else if (pads != 0 && grp == 0) begin
        err = 1'b1;
      end else if (kind == SYM_PAD) begin
        if (grp < 2) begin
          err = 1'b1;
        end else if (grp == 2) begin
          pads = 2'd1;
          acc  = {acc[11:0], 6'b000000};
          grp  = 2'd3;
          if (eom) err = 1'b1;
        end else begin
          word = {acc, 6'b000000};
          nb   = pads[0] ? 1 : 2;
          pads = {1'b0, pads[0]} + 2'd1;
          grp  = '0;
          acc  = '0;
        end
      end else if (pads != 0) begin
        err = 1'b1;
      end else if (grp == 3) begin
        word = {acc, val};
        nb   = 3;
        grp  = '0;
        acc  = '0;
      end else begin
        acc = {acc[11:0], val};
        grp = grp + 2'd1;
        // short final group
        if (eom) begin
          if (grp == 1) err = 1'b1;
          else begin
            word = {acc, 6'b000000} << (6 * (3 - int'(grp)));
            nb   = int'(grp) - 1;
          end
        end
      end

      if (err) begin
        r = '{data_byte: 8'h00, byte_valid: 1'b0, error: 1'b1, last: eom};
        pending_results.push_back(r);
        if (eom) clear_group();
        else sticky = 1'b1;
        return 1'b1;
      end

      for (int k = 0; k < nb; k++) begin
        r.data_byte  = word[23 - 8 * k -: 8];
        r.byte_valid = 1'b1;
        r.error      = 1'b0;
        r.last       = eom && (k == nb - 1);
        pending_results.push_back(r);
      end
      if (eom) clear_group();
      return 1'b1;
    endfunction

    // compare one output transfer with the oldest prediction
    function void check_output(input dec_result_t got);
      dec_result_t want;
      checked_count++;
      if (got.error) error_results++;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: byte %02h bv %b err %b last %b",
                   got.data_byte, got.byte_valid, got.error, got.last);
        return;
      end
      want = pending_results.pop_front();
      if (got != want) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("mismatch: expected byte %02h bv %b err %b last %b",
                   want.data_byte, want.byte_valid, want.error, want.last);
          $display("          got byte %02h bv %b err %b last %b",
                   got.data_byte, got.byte_valid, got.error, got.last);
        end
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  b64_in_if  in_ch();
  b64_out_if out_ch();

  b64_decode_tracker board = new();

  bit          idle_on = 1'b0;
  int          out_stall = 0;
  int          live_items = 0;
  int          sent_chars = 0;
  int          sent_msgs = 0;
  logic [7:0]  msg[$];

  base64_stream_decoder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog
  initial begin
    #2000000;
    $display("base64_stream_decoder_core_tb: done, errors");
    $finish;
  end

  // result side back-pressure in short random bursts
  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_stall = out_stall - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall = $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_output('{data_byte: out_ch.data_byte, byte_valid: out_ch.byte_valid,
                           error: out_ch.error, last: out_ch.last});
  end

  // sextet value to its alphabet character
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 6'd26) return "A" + 8'(v);
    if (v < 6'd52) return "a" + 8'(v - 6'd26);
    if (v < 6'd62) return "0" + 8'(v - 6'd52);
    if (v == 6'd62) return "+";
    return "/";
  endfunction

  // one character transfer, with an optional idle burst ahead of it
  task automatic send_symbol(input logic [7:0] sym, input logic eom);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.symbol         <= sym;
    in_ch.end_of_message <= eom;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (board.note_symbol(sym, eom)) live_items++;
    sent_chars++;
    if (eom) sent_msgs++;
  endtask

  // whole message from a string, end mark on the last character
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_symbol(s[i], i == s.len() - 1);
  endtask

  // stop sending until every predicted result has arrived
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int pick;
    int groups;
    int tail;
    int idx;
    bit drained;
    drained              = 1'b0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.symbol         = 8'h00;
    in_ch.end_of_message = 1'b0;
    out_ch.ready         = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: alphabet extremes, pads, short groups and error paths
    idle_on = 1'b1;
    send_text("AZaz09+/");
    send_text("TR==");
    send_text("TWF");
    send_symbol("=", 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b1);
    send_text("z");
    send_text("AB=");
    send_text("QUI=D");
    drain_results();

    // random messages: mostly well formed, some broken, some noise
    while (live_items < 310) begin
      msg.delete();
      idle_on = (live_items < 270) && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        repeat ($urandom_range(1, 4))
          msg.push_back(($urandom_range(0, 2) == 0) ? 8'("=") : 8'($urandom_range(0, 255)));
      end else begin
        groups = $urandom_range(0, 2);
        tail   = $urandom_range(0, 2);
        if (groups == 0 && tail == 0) tail = 1;
        repeat (groups * 4) msg.push_back(sextet_char(6'($urandom_range(0, 63))));
        if (tail != 0) begin
          repeat (tail + 1) msg.push_back(sextet_char(6'($urandom_range(0, 63))));
          if ($urandom_range(0, 1) == 1) repeat (2 - tail + 1) msg.push_back("=");
        end
        // broken variants: a substituted character or a dropped tail
        if (pick < 6) begin
          idx = $urandom_range(0, msg.size() - 1);
          msg[idx] = ($urandom_range(0, 1) == 1) ? 8'("=") : 8'($urandom_range(0, 255));
        end else if (pick < 8 && msg.size() > 1) begin
          void'(msg.pop_back());
        end
      end
      foreach (msg[i]) send_symbol(msg[i], i == msg.size() - 1);
      if (!drained && live_items >= 150) begin
        drain_results();
        drained = 1'b1;
      end
    end

    idle_on = 1'b0;
    drain_results();
    repeat (20) @(posedge clk);

    if (board.outstanding() != 0)
      $display("%0d predicted results never arrived", board.outstanding());
    $display("sent %0d characters in %0d messages, %0d of them decoded", sent_chars, sent_msgs,
             live_items);
    $display("checked %0d results, %0d of them error results", board.checked_count,
             board.error_results);
    if (board.fail_count == 0 && board.outstanding() == 0) begin
      $display("base64_stream_decoder_core_tb: done, clean");
    end else begin
      $display("base64_stream_decoder_core_tb: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/b64_pkg.sv
hdl/b64_in_if.sv
hdl/b64_out_if.sv
hdl/b64_front.sv
hdl/b64_queue.sv
hdl/b64_back.sv
hdl/base64_stream_decoder_core.sv
hdl/b64_checker.sv
bench/base64_stream_decoder_core_tb.sv
